@@ hw/rtl/ipr_pkg.sv @@
// ---------------------------------------------------------------------------
// ipr_pkg: shared types and constants for the image plane rotation core
// Register map, field widths and the control structs passed between stages.
// ---------------------------------------------------------------------------
package ipr_pkg;

  // plane store geometry and coefficient format
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 10;  // plane_width / plane_height
  localparam int COEF_W     = 16;  // sine / cosine
  localparam int POS_W      = 9;   // row / col
  localparam int PIX_W      = 8;
  localparam int DELTA_W    = SIZE_W;  // col - W/2, row - H/2
  localparam int PROD_W     = COEF_W + DELTA_W;
  localparam int S_TDATA_W  = 32;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 10'd440;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 10'd330;
  localparam logic signed [COEF_W-1:0] SINE_RST   = 16'sd13255;
  localparam logic signed [COEF_W-1:0] COSINE_RST = 16'sd9630;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_SINE         = 2'd2,
    REG_COSINE       = 2'd3
  } ipr_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } ipr_kind_t;

  // Store operation presented to the plane memory
  typedef struct packed {
    logic wr;
    logic rd;
    logic in_plane;
  } ipr_mem_ctl_t;

  // Read return from the plane memory
  typedef struct packed {
    logic vld;
    logic in_plane;
  } ipr_rd_t;

  typedef struct packed {
    logic             in_plane;
    logic [PIX_W-1:0] pixel;
  } ipr_result_t;

endpackage

@@ hw/rtl/ipr_coord.sv @@
// ---------------------------------------------------------------------------
// ipr_coord: source coordinate pipeline
// Input register, products, sums, then truncation, bounds check and store
// address. Four register stages, one item per cycle, never stalls.
// ---------------------------------------------------------------------------
module ipr_coord #(
  parameter int AW         = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_vld,
  input  ipr_pkg::ipr_kind_t                  kind,
  input  logic [ipr_pkg::POS_W-1:0]           row,
  input  logic [ipr_pkg::POS_W-1:0]           col,
  input  logic [ipr_pkg::PIX_W-1:0]           pix,
  input  logic [ipr_pkg::SIZE_W-1:0]          plane_width,
  input  logic [ipr_pkg::SIZE_W-1:0]          plane_height,
  input  logic signed [ipr_pkg::COEF_W-1:0]   sine,
  input  logic signed [ipr_pkg::COEF_W-1:0]   cosine,
  output ipr_pkg::ipr_mem_ctl_t               mem_ctl,
  output logic [AW-1:0]                       mem_addr,
  output logic [ipr_pkg::PIX_W-1:0]           mem_pix,
  output logic [2:0]                          fetch_cnt
);
  import ipr_pkg::*;

  localparam int ACC_W = ((FRAC_BITS + 9 > 26) ? FRAC_BITS + 9 : 26) + 2;
  localparam int TR_W  = ACC_W - FRAC_BITS;

  // clamped plane size and half sizes
  logic [SIZE_W-1:0] w_clamp, h_clamp;
  logic [POS_W-1:0]  hw, hh;

  always_comb begin
    if (plane_width == '0) begin
      w_clamp = SIZE_W'(1);
    end else if (int'(plane_width) > MAX_WIDTH) begin
      w_clamp = SIZE_W'(MAX_WIDTH);
    end else begin
      w_clamp = plane_width;
    end
    if (plane_height == '0) begin
      h_clamp = SIZE_W'(1);
    end else if (int'(plane_height) > MAX_HEIGHT) begin
      h_clamp = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_clamp = plane_height;
    end
    hw = w_clamp[SIZE_W-1:1];
    hh = h_clamp[SIZE_W-1:1];
  end

  // stage 1: input register with centre offsets
  logic                      s1_vld;
  ipr_kind_t                 s1_kind;
  logic [POS_W-1:0]          s1_row, s1_col;
  logic [PIX_W-1:0]          s1_pix;
  logic signed [DELTA_W-1:0] s1_dc, s1_dr;

  // stage 2: products
  logic                      s2_vld;
  ipr_kind_t                 s2_kind;
  logic [POS_W-1:0]          s2_row, s2_col;
  logic [PIX_W-1:0]          s2_pix;
  logic signed [PROD_W-1:0]  s2_sdc, s2_cdr, s2_cdc, s2_sdr;

  // stage 3: exact sums
  logic                      s3_vld;
  ipr_kind_t                 s3_kind;
  logic [POS_W-1:0]          s3_row, s3_col;
  logic [PIX_W-1:0]          s3_pix;
  logic signed [ACC_W-1:0]   s3_vr, s3_vc;

  // stage 4: store operation
  logic                      s4_vld;
  ipr_mem_ctl_t              s4_ctl;
  ipr_kind_t                 s4_kind;
  logic [AW-1:0]             s4_addr;
  logic [PIX_W-1:0]          s4_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s1_vld <= item_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind <= kind;
    s1_row  <= row;
    s1_col  <= col;
    s1_pix  <= pix;
    s1_dc   <= $signed({1'b0, col}) - $signed({1'b0, hw});
    s1_dr   <= $signed({1'b0, row}) - $signed({1'b0, hh});

    s2_kind <= s1_kind;
    s2_row  <= s1_row;
    s2_col  <= s1_col;
    s2_pix  <= s1_pix;
    s2_sdc  <= sine * s1_dc;
    s2_cdr  <= cosine * s1_dr;
    s2_cdc  <= cosine * s1_dc;
    s2_sdr  <= sine * s1_dr;

    s3_kind <= s2_kind;
    s3_row  <= s2_row;
    s3_col  <= s2_col;
    s3_pix  <= s2_pix;
    s3_vr   <= ACC_W'(s2_sdc) + ACC_W'(s2_cdr) + $signed(ACC_W'(hh) << FRAC_BITS);
    s3_vc   <= ACC_W'(s2_cdc) - ACC_W'(s2_sdr) + $signed(ACC_W'(hw) << FRAC_BITS);
  end

  // truncation toward zero: floor, plus one for a negative value with a fraction
  logic signed [TR_W-1:0] sr, sc;
  logic                   in_rows, in_cols, load_ok;
  logic [SIZE_W-1:0]      a_row, a_col;
  ipr_mem_ctl_t           ctl_next;

  always_comb begin
    sr = s3_vr[ACC_W-1:FRAC_BITS]
         + TR_W'(s3_vr[ACC_W-1] && (|s3_vr[FRAC_BITS-1:0]));
    sc = s3_vc[ACC_W-1:FRAC_BITS]
         + TR_W'(s3_vc[ACC_W-1] && (|s3_vc[FRAC_BITS-1:0]));
    in_rows = !sr[TR_W-1] && ($unsigned(sr) < TR_W'(h_clamp));
    in_cols = !sc[TR_W-1] && ($unsigned(sc) < TR_W'(w_clamp));
    load_ok = (int'(s3_row) < MAX_HEIGHT) && (int'(s3_col) < MAX_WIDTH);

    if (s3_kind == KIND_LOAD) begin
      a_row = SIZE_W'(s3_row);
      a_col = SIZE_W'(s3_col);
    end else begin
      a_row = sr[SIZE_W-1:0];
      a_col = sc[SIZE_W-1:0];
    end

    ctl_next.wr       = s3_vld && (s3_kind == KIND_LOAD) && load_ok;
    ctl_next.rd       = s3_vld && (s3_kind == KIND_FETCH);
    ctl_next.in_plane = in_rows && in_cols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl <= '0;
    end else begin
      s4_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    s4_kind <= s3_kind;
    s4_pix  <= s3_pix;
    s4_addr <= AW'(int'(a_row) * MAX_WIDTH + int'(a_col));
  end

  assign mem_ctl  = s4_ctl;
  assign mem_addr = s4_addr;
  assign mem_pix  = s4_pix;

  assign fetch_cnt = 3'(s1_vld && (s1_kind == KIND_FETCH))
                   + 3'(s2_vld && (s2_kind == KIND_FETCH))
                   + 3'(s3_vld && (s3_kind == KIND_FETCH))
                   + 3'(s4_vld && (s4_kind == KIND_FETCH));

endmodule

@@ hw/rtl/ipr_plane_mem.sv @@
// ---------------------------------------------------------------------------
// ipr_plane_mem: plane sample store
// Single port: one write or one registered read per cycle, in pipeline order.
// ---------------------------------------------------------------------------
module ipr_plane_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ipr_pkg::ipr_mem_ctl_t      ctl,
  input  logic [AW-1:0]              addr,
  input  logic [ipr_pkg::PIX_W-1:0]  wdata,
  output ipr_pkg::ipr_rd_t           rd,
  output logic [ipr_pkg::PIX_W-1:0]  rdata
);
  import ipr_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
    end else begin
      rd.vld      <= ctl.rd;
      rd.in_plane <= ctl.in_plane;
    end
  end

endmodule

@@ hw/rtl/ipr_out_fifo.sv @@
// ---------------------------------------------------------------------------
// ipr_out_fifo: result queue
// Absorbs every fetch in flight so the pipeline never has to stall.
// ---------------------------------------------------------------------------
module ipr_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  ipr_pkg::ipr_result_t              push_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ipr_pkg::PIX_W-1:0]         m_tdata,   // [7:0] pixel_out
  output logic                              m_tuser,   // [0] inside_res
  output logic [ipr_pkg::FIFO_CNT_W-1:0]    count
);
  import ipr_pkg::*;

  ipr_result_t           buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                  pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = buf_q[rd_ptr].pixel;
  assign m_tuser  = buf_q[rd_ptr].in_plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/image_plane_rotation_core.sv @@
// ---------------------------------------------------------------------------
// image_plane_rotation_core: nearest-neighbor rotation of one 8-bit plane
//
// Slave stream carries items: tuser = kind (0 load, 1 fetch), tdata holds
// row, col and the sample. A load writes the sample into the plane store and
// returns nothing. A fetch rotates (row, col) about the plane center with the
// programmed sine/cosine (Q2.FRAC_BITS) and returns the stored source sample
// on the master stream, or 0 with tuser (inside) low when the source lies
// off the plane. Fetch a sample only after it has been loaded.
// Config port writes plane width, height, sine and cosine; write only idle.
// Items pass four coordinate stages, the store read register, then an 8-entry
// result queue. One item is accepted per cycle while s_tready is high.
// s_tready drops only when queue plus fetches in flight reach 8, so a
// stalled receiver holds results in the queue and back-pressures the input.
// Reset restores width 440, height 330, sine 13255, cosine 9630 and empties
// the pipeline; store contents are left undefined.
// ---------------------------------------------------------------------------
module image_plane_rotation_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ipr_pkg::S_TDATA_W-1:0]       s_tdata,   // [8:0] row, [17:9] col,
                                                         // [25:18] pixel_in, zero pad
  input  logic                                s_tuser,   // [0] kind
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ipr_pkg::PIX_W-1:0]           m_tdata,   // [7:0] pixel_out
  output logic                                m_tuser,   // [0] inside_res
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ipr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [SIZE_W-1:0]         plane_width, plane_height;
  logic signed [COEF_W-1:0]  sine_q14, cosine_q14;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width  <= WIDTH_RST;
      plane_height <= HEIGHT_RST;
      sine_q14     <= SINE_RST;
      cosine_q14   <= COSINE_RST;
    end else if (cfg_valid) begin
      unique case (ipr_reg_t'(cfg_index))
        REG_PLANE_WIDTH:  plane_width  <= cfg_data[SIZE_W-1:0];
        REG_PLANE_HEIGHT: plane_height <= cfg_data[SIZE_W-1:0];
        REG_SINE:         sine_q14     <= $signed(cfg_data);
        REG_COSINE:       cosine_q14   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic                  in_vld;
  ipr_mem_ctl_t          mem_ctl;
  logic [AW-1:0]         mem_addr;
  logic [PIX_W-1:0]      mem_pix;
  logic [2:0]            fetch_cnt;
  ipr_rd_t               rd;
  logic [PIX_W-1:0]      rdata;
  ipr_result_t           result;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W-1:0] occupancy;

  assign in_vld = s_tvalid && s_tready;

  // reserve a queue slot for every fetch accepted but not yet queued
  assign occupancy = FIFO_CNT_W'(fetch_cnt) + FIFO_CNT_W'(rd.vld) + fifo_cnt;
  assign s_tready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));

  ipr_coord #(
    .AW         (AW)
  ) u_coord (
    .clk          (clk),
    .rst          (rst),
    .item_vld     (in_vld),
    .kind         (ipr_kind_t'(s_tuser)),
    .row          (s_tdata[8:0]),
    .col          (s_tdata[17:9]),
    .pix          (s_tdata[25:18]),
    .plane_width  (plane_width),
    .plane_height (plane_height),
    .sine         (sine_q14),
    .cosine       (cosine_q14),
    .mem_ctl      (mem_ctl),
    .mem_addr     (mem_addr),
    .mem_pix      (mem_pix),
    .fetch_cnt    (fetch_cnt)
  );

  ipr_plane_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_pix),
    .rd    (rd),
    .rdata (rdata)
  );

  assign result.in_plane = rd.in_plane;
  assign result.pixel    = rd.in_plane ? rdata : '0;

  ipr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rd.vld),
    .push_data (result),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .count     (fifo_cnt)
  );

endmodule
